// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the Modbus RTU master RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/mrm_pkg.sv =====
// ----------------------------------------------------------------------------
// mrm_pkg
// Types and constants shared by the Modbus RTU master modules.
// ----------------------------------------------------------------------------
package mrm_pkg;

	// input word kinds
	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_BYTE  = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;

	// result word kinds
	localparam logic [1:0] KIND_TX   = 2'd0;
	localparam logic [1:0] KIND_STAT = 2'd1;
	localparam logic [1:0] KIND_WORD = 2'd2;

	// completion status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_SLAVE   = 3'd1;
	localparam logic [2:0] ST_FUNC    = 3'd2;
	localparam logic [2:0] ST_EXC     = 3'd3;
	localparam logic [2:0] ST_TIMEOUT = 3'd4;
	localparam logic [2:0] ST_CRC     = 3'd5;

	// CRC-16 constants
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [15:0] TIMEOUT_RST = 16'd2000;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  slave_id;
		logic [6:0]  function_code;
		logic [15:0] start_address;
		logic [15:0] quantity;
		logic [7:0]  rx_byte;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic [2:0]  status;
		logic [7:0]  exception_code;
		logic [5:0]  word_index;
		logic [15:0] word_value;
		logic        last;
	} rsp_t;

	// CRC unit control and status
	typedef struct packed {
		logic       init;
		logic       start;
		logic [7:0] data;
	} crc_ctrl_t;

	typedef struct packed {
		logic        busy;
		logic [15:0] crc;
	} crc_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TXFEED,
		S_TXWAIT,
		S_TXOUT,
		S_RXCRC,
		S_RXCHK,
		S_TICK,
		S_STAT,
		S_DRDLO,
		S_DRDHI,
		S_DOUT
	} state_t;

endpackage

// ===== rtl/mrm_ram.sv =====
// ----------------------------------------------------------------------------
// mrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/mrm_crc_serial.sv =====
// ----------------------------------------------------------------------------
// mrm_crc_serial
// Bit-serial CRC-16 (reflected 0xA001), one bit per cycle.
// ----------------------------------------------------------------------------
module mrm_crc_serial
	import mrm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  crc_ctrl_t ctrl,
	output crc_stat_t stat
);

	logic [15:0] crc_q;
	logic [7:0]  sh_q;
	logic [2:0]  cnt_q;
	logic        busy_q;
	logic        fb;

	// feedback bit: crc lsb against next data bit, lsb first
	assign fb = crc_q[0] ^ sh_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else if (ctrl.init) begin
			crc_q  <= CRC_INIT;
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 3'd0;
		end else if (busy_q) begin
			crc_q <= (crc_q >> 1) ^ (fb ? CRC_POLY : 16'h0000);
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	// data shifter
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			sh_q <= ctrl.data;
		end else if (busy_q) begin
			sh_q <= sh_q >> 1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.crc  = crc_q;

endmodule

// ===== rtl/modbus_rtu_master_transaction.sv =====
// Start request: CRC over the 6 header bytes, then 8 bytes out at one per cycle while the output is not stalled.
// Received byte: bit-serial CRC in S_RXCRC, a check in S_RXCHK, then back to idle, or on to status or word output.
// Tick: compared with the timeout in S_TICK. Decoded reply words: low and high byte from the frame RAM read port.
// One input word is worked on at a time; req_stall is low only when idle.
// arst_n clears all control state; timeout register resets to 2000 ticks.
// ----------------------------------------------------------------------------
// modbus_rtu_master_transaction
// Modbus RTU master: builds the request with its CRC, checks and decodes the reply.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module modbus_rtu_master_transaction
	import mrm_pkg::*;
#(
	parameter int MAX_WORDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp_data,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	localparam int RAM_DEPTH = 2 * MAX_WORDS;
	localparam int AW        = $clog2(RAM_DEPTH);
	localparam int WIDX      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int WW        = $clog2(MAX_WORDS + 1);
	localparam logic [8:0] STORE_END = 9'(2 * MAX_WORDS + 3);
	localparam logic [8:0] MW9       = 9'(MAX_WORDS);

	state_t state_q, state_d;

	logic        phase_q;
	logic [15:0] timeout_q;
	logic [7:0]  exp_slave_q;
	logic [6:0]  exp_func_q;
	logic [8:0]  rcv_q;
	logic [7:0]  rem_q;
	logic [15:0] elapsed_q;
	logic [2:0]  cnt_q;
	logic [47:0] req_q;
	logic [7:0]  hdr0_q, hdr1_q, hdr2_q;
	logic [2:0]  st_q;
	logic [7:0]  exc_q;
	logic [WW-1:0]   words_q;
	logic [WIDX-1:0] wi_q;
	logic        coils_q;
	logic [7:0]  lo_q;

	logic      rsp_valid_q;
	rsp_t      rsp_q;

	crc_ctrl_t crc_ctrl;
	crc_stat_t crc_stat;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_rdata;

	logic     acc, out_free, out_ld;
	rsp_t     out_nxt;
	logic [7:0] tx_sel;

	// reply check signals
	logic [6:0] fn;
	logic       chk5, fail, is_coil, is_reg;
	logic [2:0] fail_st;
	logic [7:0] cls_rem, rem_eff, wraw;
	logic [WW-1:0] words_c;
	logic [WW-1:0] wi_ext;
	logic [WIDX+5:0] wi_out;
	logic [8:0]  hi_pos;
	logic [7:0]  hi_byte;

	assign acc      = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;

	mrm_crc_serial u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.stat   (crc_stat)
	);

	mrm_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req_data.rx_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// request byte select: six header bytes then CRC low, high
	always_comb begin
		case (cnt_q)
			3'd0:    tx_sel = req_q[47:40];
			3'd1:    tx_sel = req_q[39:32];
			3'd2:    tx_sel = req_q[31:24];
			3'd3:    tx_sel = req_q[23:16];
			3'd4:    tx_sel = req_q[15:8];
			3'd5:    tx_sel = req_q[7:0];
			3'd6:    tx_sel = crc_stat.crc[7:0];
			default: tx_sel = crc_stat.crc[15:8];
		endcase
	end

	// header checks at the fifth byte, and expected length by function class
	assign fn      = hdr1_q[6:0];
	assign chk5    = (rcv_q == 9'd5);
	assign is_coil = (fn == 7'd1) || (fn == 7'd2);
	assign is_reg  = (fn == 7'd3) || (fn == 7'd4) || (fn == 7'd23);

	always_comb begin
		fail    = 1'b1;
		fail_st = ST_OK;
		if (hdr0_q != exp_slave_q) begin
			fail_st = ST_SLAVE;
		end else if (fn != exp_func_q) begin
			fail_st = ST_FUNC;
		end else if (hdr1_q[7]) begin
			fail_st = ST_EXC;
		end else begin
			fail = 1'b0;
		end
		fail = fail && chk5;
	end

	always_comb begin
		case (fn)
			7'd1, 7'd2, 7'd3, 7'd4, 7'd23: cls_rem = hdr2_q;
			7'd5, 7'd6, 7'd15, 7'd16:      cls_rem = 8'd3;
			7'd22:                         cls_rem = 8'd5;
			default:                       cls_rem = rem_q;
		endcase
	end

	assign rem_eff = chk5 ? cls_rem : rem_q;

	// word count, clipped
	always_comb begin
		if (is_coil) begin
			wraw = (hdr2_q >> 1) + {7'd0, hdr2_q[0]};
		end else if (is_reg) begin
			wraw = hdr2_q >> 1;
		end else begin
			wraw = 8'd0;
		end
		words_c = ({1'b0, wraw} > MW9) ? WW'(MAX_WORDS) : WW'(wraw);
	end

	// decoded word high byte: coil reply past the byte count pads with zero
	assign wi_ext  = WW'(wi_q);
	assign hi_pos  = 9'({wi_q, 1'b0}) + 9'd2;
	assign hi_byte = (coils_q && (hi_pos > {1'b0, hdr2_q})) ? 8'd0 : ram_rdata;
	assign wi_out  = {6'd0, wi_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (req_data.func == FUNC_START) begin
						state_d = S_TXFEED;
					end else if (phase_q && req_data.func == FUNC_BYTE) begin
						state_d = S_RXCRC;
					end else if (phase_q && req_data.func == FUNC_TICK) begin
						state_d = S_TICK;
					end
				end
			end
			S_TXFEED: state_d = S_TXWAIT;
			S_TXWAIT: begin
				if (!crc_stat.busy) begin
					state_d = (cnt_q == 3'd5) ? S_TXOUT : S_TXFEED;
				end
			end
			S_TXOUT: begin
				if (out_free && cnt_q == 3'd7) begin
					state_d = S_IDLE;
				end
			end
			S_RXCRC: begin
				if (!crc_stat.busy) begin
					state_d = S_RXCHK;
				end
			end
			S_RXCHK: begin
				if (fail) begin
					state_d = S_STAT;
				end else if (rem_eff == 8'd0) begin
					if (crc_stat.crc != 16'h0000 || words_c == '0) begin
						state_d = S_STAT;
					end else begin
						state_d = S_DRDLO;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			S_TICK: state_d = (elapsed_q > timeout_q) ? S_STAT : S_IDLE;
			S_STAT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_DRDLO: state_d = S_DRDHI;
			S_DRDHI: state_d = S_DOUT;
			S_DOUT: begin
				if (out_free) begin
					state_d = ((wi_ext + WW'(1)) == words_q) ? S_IDLE : S_DRDLO;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		req_stall     = 1'b1;
		crc_ctrl      = '0;
		ram_we        = 1'b0;
		ram_waddr     = AW'(rcv_q - 9'd3);
		ram_re        = 1'b0;
		ram_raddr     = AW'({wi_q, 1'b0});
		out_ld        = 1'b0;
		out_nxt       = '0;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (acc && req_data.func == FUNC_START) begin
					crc_ctrl.init = 1'b1;
				end else if (acc && phase_q && req_data.func == FUNC_BYTE) begin
					crc_ctrl.start = 1'b1;
					crc_ctrl.data  = req_data.rx_byte;
					ram_we = (rcv_q >= 9'd3) && (rcv_q < STORE_END);
				end
			end
			S_TXFEED: begin
				crc_ctrl.start = 1'b1;
				crc_ctrl.data  = tx_sel;
			end
			S_TXOUT: begin
				if (out_free) begin
					out_ld          = 1'b1;
					out_nxt.kind    = KIND_TX;
					out_nxt.tx_byte = tx_sel;
					out_nxt.last    = (cnt_q == 3'd7);
					crc_ctrl.init   = (cnt_q == 3'd7);
				end
			end
			S_STAT: begin
				if (out_free) begin
					out_ld                 = 1'b1;
					out_nxt.kind           = KIND_STAT;
					out_nxt.status         = st_q;
					out_nxt.exception_code = exc_q;
					out_nxt.last           = 1'b1;
				end
			end
			S_DRDLO: begin
				ram_re = 1'b1;
			end
			S_DRDHI: begin
				ram_re    = 1'b1;
				ram_raddr = AW'({wi_q, 1'b1});
			end
			S_DOUT: begin
				if (out_free) begin
					out_ld             = 1'b1;
					out_nxt.kind       = KIND_WORD;
					out_nxt.word_index = wi_out[5:0];
					out_nxt.word_value = coils_q ? {hi_byte, lo_q} : {lo_q, hi_byte};
					out_nxt.last       = ((wi_ext + WW'(1)) == words_q);
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= 1'b0;
			timeout_q   <= TIMEOUT_RST;
			rcv_q       <= 9'd0;
			rem_q       <= 8'd8;
			elapsed_q   <= 16'd0;
			cnt_q       <= 3'd0;
			wi_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
			if (out_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc && req_data.func == FUNC_START) begin
						phase_q   <= 1'b1;
						rcv_q     <= 9'd0;
						rem_q     <= 8'd8;
						elapsed_q <= 16'd0;
						cnt_q     <= 3'd0;
					end else if (acc && phase_q && req_data.func == FUNC_BYTE) begin
						if (rcv_q != 9'd511) begin
							rcv_q <= rcv_q + 9'd1;
						end
						if (rem_q != 8'd0) begin
							rem_q <= rem_q - 8'd1;
						end
					end else if (acc && phase_q && req_data.func == FUNC_TICK) begin
						if (elapsed_q != 16'hFFFF) begin
							elapsed_q <= elapsed_q + 16'd1;
						end
					end
				end
				S_TXWAIT: begin
					if (!crc_stat.busy) begin
						cnt_q <= (cnt_q == 3'd5) ? 3'd0 : cnt_q + 3'd1;
					end
				end
				S_TXOUT: begin
					if (out_free) begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_RXCHK: begin
					rem_q <= rem_eff;
					if (fail || rem_eff == 8'd0) begin
						phase_q <= 1'b0;
					end
					wi_q <= '0;
				end
				S_TICK: begin
					if (elapsed_q > timeout_q) begin
						phase_q <= 1'b0;
					end
				end
				S_DOUT: begin
					if (out_free) begin
						wi_q <= wi_q + WIDX'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (out_ld) begin
			rsp_q <= out_nxt;
		end
		if (state_q == S_IDLE && acc && req_data.func == FUNC_START) begin
			req_q <= {req_data.slave_id, 1'b0, req_data.function_code,
				req_data.start_address, req_data.quantity};
			exp_slave_q <= req_data.slave_id;
			exp_func_q  <= req_data.function_code;
		end
		if (state_q == S_IDLE && acc && phase_q && req_data.func == FUNC_BYTE) begin
			if (rcv_q == 9'd0) begin
				hdr0_q <= req_data.rx_byte;
			end
			if (rcv_q == 9'd1) begin
				hdr1_q <= req_data.rx_byte;
			end
			if (rcv_q == 9'd2) begin
				hdr2_q <= req_data.rx_byte;
			end
		end
		if (state_q == S_RXCHK) begin
			words_q <= words_c;
			coils_q <= is_coil;
			exc_q   <= 8'd0;
			if (fail) begin
				st_q <= fail_st;
				if (fail_st == ST_EXC) begin
					exc_q <= hdr2_q;
				end
			end else if (crc_stat.crc != 16'h0000) begin
				st_q <= ST_CRC;
			end else begin
				st_q <= ST_OK;
			end
		end
		if (state_q == S_TICK) begin
			st_q  <= ST_TIMEOUT;
			exc_q <= 8'd0;
		end
		if (state_q == S_DRDHI) begin
			lo_q <= ram_rdata;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	`ASSERT_IMP(a_crc_busy_wait, clk, arst_n, crc_stat.busy, (state_q == S_TXWAIT || state_q == S_RXCRC))
	`ASSERT_IMP(a_word_in_range, clk, arst_n, (state_q == S_DOUT), (wi_ext < words_q))
	`ASSERT_IMP(a_stat_ends_run, clk, arst_n, (state_q == S_STAT), !phase_q)

endmodule
